// File: rtl/core/nsr_pkg.sv
package nsr_pkg;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharG      = 8'h47;
  localparam logic [7:0] CharS      = 8'h53;
  localparam logic [7:0] CharR      = 8'h52;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharLf     = 8'h0A;

  localparam logic [7:0] MaxLengthReset = 8'd88;
  localparam logic [3:0] IndexLimit     = 4'd10;
  localparam logic [3:0] IndexRmc       = 4'd3;
  localparam logic [3:0] IndexGgaGsv    = 4'd4;

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhSync   = 2'd1;
  localparam logic [1:0] PhCopy   = 2'd2;
  localparam logic [1:0] PhWaitLf = 2'd3;

  localparam logic [1:0] KindGga = 2'd0;
  localparam logic [1:0] KindGsv = 2'd1;
  localparam logic [1:0] KindRmc = 2'd2;

  localparam int unsigned AddrWidth = 3;
  localparam logic RegMaxLength = 1'b0;

  typedef struct packed {
    logic [1:0] sentence_kind;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       sentence_end;
  } result_t;

endpackage

// File: rtl/core/nsr_if.sv
interface nsr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] sentence_kind;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       sentence_end;

  modport source (output valid, output sentence_kind, output data_byte,
                  output first_byte, output sentence_end, input ready);
  modport sink (input valid, input sentence_kind, input data_byte,
                input first_byte, input sentence_end, output ready);
endinterface

// File: rtl/core/nsr_apb_regs.sv
module nsr_apb_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nsr_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [7:0]                     max_length_o
);

  logic [7:0] max_length_q, max_length_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    max_length_d = max_length_q;
    if (wr_en && (paddr[2] == nsr_pkg::RegMaxLength)) begin
      max_length_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= nsr_pkg::MaxLengthReset;
    end else begin
      max_length_q <= max_length_d;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == nsr_pkg::RegMaxLength) begin
      prdata = {24'd0, max_length_q};
    end
  end

  assign max_length_o = max_length_q;

endmodule

// File: rtl/core/nsr_parser.sv
module nsr_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic [7:0]       max_length_i,
  output logic             emit_o,
  output nsr_pkg::result_t result_o
);

  logic [1:0] phase_q, phase_d;
  logic [3:0] index_q, index_d;
  logic [7:0] count_q, count_d;
  logic [1:0] kind_q, kind_d;

  logic [1:0] ph0, ph1;
  logic [3:0] idx0;
  logic [7:0] cnt0;
  logic [8:0] next_cnt;
  logic       is_dollar, sel_gs, sel_r, sel;

  always_comb begin
    is_dollar = (byte_i == nsr_pkg::CharDollar);
    ph0  = is_dollar ? nsr_pkg::PhSync : phase_q;
    idx0 = is_dollar ? 4'd0 : index_q;

    sel_gs = (ph0 == nsr_pkg::PhSync) && (idx0 == nsr_pkg::IndexGgaGsv) &&
             ((byte_i == nsr_pkg::CharG) || (byte_i == nsr_pkg::CharS));
    sel_r  = (ph0 == nsr_pkg::PhSync) && (idx0 == nsr_pkg::IndexRmc) &&
             (byte_i == nsr_pkg::CharR);
    sel    = sel_gs || sel_r;

    kind_d = kind_q;
    if (sel_r) begin
      kind_d = nsr_pkg::KindRmc;
    end else if (sel_gs) begin
      kind_d = (byte_i == nsr_pkg::CharG) ? nsr_pkg::KindGga : nsr_pkg::KindGsv;
    end

    ph1      = sel ? nsr_pkg::PhCopy : ph0;
    cnt0     = sel ? 8'd0 : count_q;
    next_cnt = {1'b0, cnt0} + 9'd1;

    phase_d = ph1;
    count_d = cnt0;
    emit_o  = 1'b0;
    result_o.sentence_kind = kind_d;
    result_o.data_byte     = byte_i;
    result_o.first_byte    = sel;
    result_o.sentence_end  = 1'b0;

    if (ph1 == nsr_pkg::PhCopy) begin
      emit_o  = 1'b1;
      count_d = next_cnt[7:0];
      if (next_cnt > {1'b0, max_length_i}) begin
        phase_d = nsr_pkg::PhIdle;
      end else if (byte_i == nsr_pkg::CharCr) begin
        phase_d = nsr_pkg::PhWaitLf;
      end
    end else if ((ph1 == nsr_pkg::PhWaitLf) && (byte_i == nsr_pkg::CharLf)) begin
      emit_o  = 1'b1;
      phase_d = nsr_pkg::PhIdle;
      result_o.sentence_end = 1'b1;
    end

    index_d = (idx0 < nsr_pkg::IndexLimit) ? idx0 + 4'd1 : idx0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nsr_pkg::PhIdle;
      index_q <= 4'd0;
      count_q <= 8'd0;
      kind_q  <= nsr_pkg::KindGga;
    end else if (step_i) begin
      phase_q <= phase_d;
      index_q <= index_d;
      count_q <= count_d;
      kind_q  <= kind_d;
    end
  end

endmodule

// File: rtl/core/nsr_out_reg.sv
module nsr_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  nsr_pkg::result_t result_i,
  output logic             free_o,
  nsr_out_if.source        tx
);

  logic             valid_q, valid_d;
  nsr_pkg::result_t data_q;

  assign free_o = !valid_q || tx.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (tx.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign tx.valid         = valid_q;
  assign tx.sentence_kind = data_q.sentence_kind;
  assign tx.data_byte     = data_q.data_byte;
  assign tx.first_byte    = data_q.first_byte;
  assign tx.sentence_end  = data_q.sentence_end;

endmodule

// File: rtl/core/nmea_sentence_router.sv
// Data path: input register, then the parser, then the output register.
// Throughput: one byte per cycle, set by the input register feeding the parser
// and a single output register; a held output stalls only bytes that emit.
// Reset: rst_ni clears the parser to idle, empties both registers and sets
// max_length to 88. No clearing pass is needed.
module nmea_sentence_router (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nsr_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  nsr_in_if.sink                        rx_i,
  nsr_out_if.source                     tx_o
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic [7:0]       max_length;
  logic             emit;
  logic             out_free;
  logic             advance;
  nsr_pkg::result_t result;

  nsr_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_length_o (max_length)
  );

  assign advance  = in_valid_q && (!emit || out_free);
  assign rx_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  nsr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (in_byte_q),
    .max_length_i (max_length),
    .emit_o       (emit),
    .result_o     (result)
  );

  nsr_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && emit),
    .result_i (result),
    .free_o   (out_free),
    .tx       (tx_o)
  );

endmodule
